### hdl/sps_pkg.sv
// Shared types and constants for the segment pixel scan serialiser.
// No dependencies; imported by the top level, its checker and the testbench.
`timescale 1ns / 1ps

package sps_pkg;

	localparam int FRAME_WIDTH  = 96;
	localparam int FRAME_HEIGHT = 26;
	localparam int FRAME_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W       = $clog2(FRAME_DEPTH);
	localparam int PIXEL_BITS   = 40;
	localparam int STREAM_BITS  = 48;
	localparam int IDX_W        = $clog2(STREAM_BITS);

	// Request opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EMIT  = 1'b1;

	typedef struct packed {
		logic       op;
		logic [6:0] pix_x;
		logic [4:0] pix_y;
		logic       pix_value;
		logic       board_select;
		logic [3:0] segment_index;
		logic       second_pass;
	} req_t;

	typedef struct packed {
		logic bit_out;
		logic last_bit;
	} res_t;

endpackage

### hdl/segment_pixel_scan_serializer.sv
// Segment pixel scan serialiser: 96x26 one-bit frame store and 48-bit segment stream.
// Depends on sps_pkg.
`timescale 1ns / 1ps

// After reset the block clears its frame store, one pixel a cycle, with busy
// held high. A write request does not raise busy. An emit request puts out
// 48 bits, one per cycle on consecutive cycles marked by strobe; the request
// is registered into the sequencer state, and each bit then passes the registered
// read and the output stage. Busy stays high while the bits are issued. The bit
// rate is set by the single read port of the frame store, which yields one
// pixel a cycle. The receiver cannot stall: each bit is shown for one cycle.
module segment_pixel_scan_serializer
	import sps_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output logic strobe,
	output res_t result
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(FRAME_DEPTH - 1);
	localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(STREAM_BITS - 1);
	localparam logic [IDX_W-1:0]  IDX_PASS = IDX_W'(PIXEL_BITS);

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [IDX_W-1:0]  idx_q;
	logic signed [3:0] col_q;
	logic [2:0]        step_q;
	logic [3:0]        seg_q;
	logic              top_q;
	logic              pass_q;

	logic              valid_s1;
	logic              pix_s1;
	logic              ok_s1;
	logic              fixed_s1;
	logic              last_s1;

	logic              mem [FRAME_DEPTH];
	logic              rd_q;

	logic              accept;
	logic              wr_in_frame;
	logic [ADDR_W-1:0] wr_addr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic              mem_wdata;

	logic [6:0]        seg6;
	logic signed [8:0] px_base;
	logic signed [8:0] px_fold;
	logic signed [8:0] px;
	logic [4:0]        py_base;
	logic [4:0]        py_fold;
	logic [4:0]        py;
	logic              fold;
	logic              rd_ok;
	logic [ADDR_W-1:0] rd_addr;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Write address and frame bounds of a pixel write request
	assign wr_in_frame = (request.pix_x < 7'(FRAME_WIDTH)) && (request.pix_y < 5'(FRAME_HEIGHT));
	assign wr_addr = ADDR_W'({request.pix_y, 6'b0}) + ADDR_W'({request.pix_y, 5'b0})
		+ ADDR_W'(request.pix_x);

	// Scan path coordinate for the current bit
	always_comb begin
		seg6    = 7'({seg_q, 2'b0}) + 7'({seg_q, 1'b0});
		px_base = $signed({2'b00, seg6}) + 9'(col_q);
		py_base = 5'd12 + 5'({step_q, 1'b0}) + 5'(pass_q);
		fold    = (step_q == 3'd0) && !pass_q;
		px_fold = fold ? (px_base - 9'sd1) : px_base;
		py_fold = fold ? 5'd13 : py_base;
		px      = top_q ? (9'sd95 - px_fold) : px_fold;
		py      = top_q ? (5'd25 - py_fold) : py_fold;
		rd_ok   = !px[8] && (px[7:0] < 8'(FRAME_WIDTH));
		rd_addr = ADDR_W'({py, 6'b0}) + ADDR_W'({py, 5'b0}) + ADDR_W'(px[6:0]);
	end

	// Frame store write port: clearing sweep or pixel write
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_addr;
		mem_wdata = request.pix_value;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = 1'b0;
		end else if (accept && (request.op == OP_WRITE) && wr_in_frame) begin
			mem_we = 1'b1;
		end
	end

	// Frame store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[rd_addr];
	end

	// Sequencer: clearing sweep, idle, and bit issue for an emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (request.op == OP_EMIT)) begin
						state_q <= ST_EMIT;
						idx_q   <= '0;
					end
				end
				ST_EMIT: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Path walker: column and row step along the staggered column path
	always_ff @(posedge clk) begin
		if (accept && (request.op == OP_EMIT)) begin
			seg_q  <= request.segment_index;
			top_q  <= !request.board_select;
			pass_q <= request.second_pass;
			col_q  <= request.segment_index[0] ? -4'sd1 : 4'sd0;
			step_q <= request.segment_index[0] ? 3'd6 : 3'd1;
		end else if (state_q == ST_EMIT) begin
			if (step_q < 3'd6) begin
				step_q <= step_q + 3'd1;
			end else begin
				col_q  <= col_q + 4'sd1;
				// new column odd when the old one was even
				step_q <= col_q[0] ? 3'd1 : 3'd0;
			end
		end
	end

	// Output stage, aligned with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		pix_s1   <= (idx_q < IDX_PASS);
		ok_s1    <= rd_ok;
		fixed_s1 <= (idx_q == IDX_PASS) && pass_q;
		last_s1  <= (idx_q == IDX_LAST);
	end

	assign strobe          = valid_s1;
	assign result.bit_out  = pix_s1 ? (ok_s1 && rd_q) : fixed_s1;
	assign result.last_bit = last_s1;

endmodule

### hdl/sps_checker.sv
// Port-level checker for segment_pixel_scan_serializer, with its bind.
// Depends on sps_pkg.
`timescale 1ns / 1ps

module sps_checker
	import sps_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input req_t request,
	input logic busy,
	input logic strobe,
	input res_t result
);

	// An accepted emit request occupies the block
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (request.op == OP_EMIT) |=> busy)
		else $error("emit request did not raise busy");

	// Stream bits are back to back until the last one
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_bit |=> strobe)
		else $error("gap inside a segment stream");

	// Nothing follows the last bit directly
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_bit |=> !strobe)
		else $error("strobe straight after last bit");

	// Mid-stream the block does not take new requests
	a_busy_mid_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_bit |-> busy)
		else $error("block idle in the middle of a stream");

endmodule

bind segment_pixel_scan_serializer sps_checker u_sps_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.request (request),
	.busy    (busy),
	.strobe  (strobe),
	.result  (result)
);

### tb/sv/segment_pixel_scan_serializer_tb.sv
// Self-checking testbench for the segment pixel scan serialiser: directed table then random
// pixel writes and segment emits, each 48-bit stream checked against its row or the scan model.
// Depends on sps_pkg and segment_pixel_scan_serializer.
`timescale 1ns / 1ps

module segment_pixel_scan_serializer_tb;
	import sps_pkg::*;

	localparam int STALL_LIMIT = 15000;  // several times as long as the clearing sweep after reset
	localparam int RANDOM_ITEMS = 96;
	localparam int DIR_ROWS = 25;

	typedef struct {
		req_t        req;
		bit          typed;      // stream given in the row, not predicted
		logic [47:0] stream;     // bit k is the k-th serial bit
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic strobe;
	res_t result;

	bit   frame_px [FRAME_DEPTH];
	res_t expected_bits [$];
	int   bit_pos = 0;
	int   mismatches = 0;
	int   quiet_cycles = 0;
	int   idle_pct = 0;

	segment_pixel_scan_serializer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Scan model: frame store plus the staggered column path
	function automatic bit pixel_at(int px, int py);
		if (px < 0 || px >= FRAME_WIDTH || py < 0 || py >= FRAME_HEIGHT)
			return 1'b0;
		return frame_px[py * FRAME_WIDTH + px];
	endfunction

	function automatic void store_pixel(req_t r);
		if (r.pix_x < FRAME_WIDTH && r.pix_y < FRAME_HEIGHT)
			frame_px[int'(r.pix_y) * FRAME_WIDTH + int'(r.pix_x)] = r.pix_value;
	endfunction

	function automatic void scan_segment(req_t r);
		int   seg;
		int   pass_i;
		int   col;
		int   stp;
		int   px;
		int   py;
		bit   top;
		res_t e;
		seg = r.segment_index;
		pass_i = r.second_pass;
		top = (r.board_select == 1'b0);
		col = r.segment_index[0] ? -1 : 0;
		stp = r.segment_index[0] ? 6 : 1;
		for (int k = 0; k < PIXEL_BITS; k++) begin
			px = seg * 6 + col;
			py = 12 + 2 * stp + pass_i;
			// row 12 folds onto row 13 of the previous column
			if (py == 12) begin
				px = px - 1;
				py = 13;
			end
			if (top) begin
				px = (FRAME_WIDTH - 1) - px;
				py = (FRAME_HEIGHT - 1) - py;
			end
			e.bit_out = pixel_at(px, py);
			e.last_bit = 1'b0;
			expected_bits.push_back(e);
			if (stp < 6) begin
				stp++;
			end else begin
				col++;
				stp = (col % 2 != 0) ? 0 : 1;
			end
		end
		// trailer: pass bit then seven zeros, last one flagged
		for (int k = PIXEL_BITS; k < STREAM_BITS; k++) begin
			e.bit_out = (k == PIXEL_BITS) ? r.second_pass : 1'b0;
			e.last_bit = (k == STREAM_BITS - 1);
			expected_bits.push_back(e);
		end
	endfunction

	function automatic req_t wr(int x, int y, bit v);
		req_t r;
		r = '0;
		r.op = OP_WRITE;
		r.pix_x = 7'(x);
		r.pix_y = 5'(y);
		r.pix_value = v;
		return r;
	endfunction

	function automatic req_t em(bit board, int seg, bit pass_b);
		req_t r;
		r = '0;
		r.op = OP_EMIT;
		r.board_select = board;
		r.segment_index = 4'(seg);
		r.second_pass = pass_b;
		return r;
	endfunction

	// Present one request, idling at random first; returns at the accepting edge
	task automatic issue(input req_t r, input bit typed, input logic [47:0] stream);
		bit   ok;
		res_t e;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		do begin
			@(negedge clk);
			ok = !busy;
			@(posedge clk);
		end while (!ok);
		if (r.op == OP_WRITE) begin
			store_pixel(r);
		end else if (typed) begin
			for (int k = 0; k < STREAM_BITS; k++) begin
				e.bit_out = stream[k];
				e.last_bit = (k == STREAM_BITS - 1);
				expected_bits.push_back(e);
			end
		end else begin
			scan_segment(r);
		end
	endtask

	// Result check, sampled mid-cycle while the strobe is shown
	always @(negedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (expected_bits.size() == 0) begin
				$display("%0t unexpected bit: bit_out=%b last_bit=%b", $time,
					result.bit_out, result.last_bit);
				mismatches++;
			end else begin
				res_t e;
				e = expected_bits.pop_front();
				if (result.bit_out !== e.bit_out) begin
					$display("%0t bit %0d bit_out: expected %b, got %b", $time,
						bit_pos, e.bit_out, result.bit_out);
					mismatches++;
				end
				if (result.last_bit !== e.last_bit) begin
					$display("%0t bit %0d last_bit: expected %b, got %b", $time,
						bit_pos, e.last_bit, result.last_bit);
					mismatches++;
				end
				bit_pos = e.last_bit ? 0 : bit_pos + 1;
			end
		end
	end

	// Watchdog: cycles with neither a request taken nor a bit shown
	always @(negedge clk) begin
		if ((start && busy === 1'b0) || strobe === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t watchdog expired", $time);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		dir_row_t    rows [DIR_ROWS];
		bit [31:0]   raw;
		req_t        r;

		// After reset the store is blank: only the pass bit can be lit
		rows = '{
			'{em(1'b1, 0, 1'b0), 1'b1, 48'h0000_0000_0000},
			'{em(1'b0, 15, 1'b1), 1'b1, 48'h0100_0000_0000},
			'{em(1'b1, 15, 1'b1), 1'b1, 48'h0100_0000_0000},
			'{wr(0, 0, 1'b1), 1'b0, '0},
			'{wr(95, 25, 1'b1), 1'b0, '0},
			'{wr(95, 0, 1'b1), 1'b0, '0},
			'{wr(0, 25, 1'b1), 1'b0, '0},
			'{wr(127, 31, 1'b1), 1'b0, '0},     // outside: ignored
			'{wr(96, 14, 1'b1), 1'b0, '0},
			'{wr(0, 26, 1'b1), 1'b0, '0},
			'{wr(0, 14, 1'b1), 1'b0, '0},
			'{wr(0, 15, 1'b1), 1'b0, '0},
			'{wr(5, 24, 1'b1), 1'b0, '0},
			'{wr(6, 13, 1'b1), 1'b0, '0},       // reached by the row-12 fold
			'{wr(95, 11, 1'b1), 1'b0, '0},
			'{em(1'b1, 0, 1'b0), 1'b0, '0},
			'{em(1'b1, 0, 1'b1), 1'b0, '0},
			'{em(1'b1, 1, 1'b0), 1'b0, '0},
			'{em(1'b1, 1, 1'b1), 1'b0, '0},
			'{em(1'b0, 0, 1'b0), 1'b0, '0},
			'{em(1'b0, 0, 1'b1), 1'b0, '0},
			'{em(1'b0, 15, 1'b0), 1'b0, '0},
			'{wr(0, 14, 1'b0), 1'b0, '0},
			'{em(1'b1, 0, 1'b0), 1'b0, '0},
			'{em(1'b0, 1, 1'b1), 1'b0, '0}
		};

		foreach (frame_px[i])
			frame_px[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++)
			issue(rows[i].req, rows[i].typed, rows[i].stream);

		// random writes and emits, in idling phases
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case (i / (RANDOM_ITEMS / 4))
				0: begin
					idle_pct = 0;
				end
				1: begin
					idle_pct = 73;
				end
				2: begin
					idle_pct = 0;
				end
				default: begin
					idle_pct = 19;
				end
			endcase
			raw = $urandom;
			r = raw[$bits(req_t)-1:0];
			if ($urandom_range(99) < 40) begin
				r.op = OP_WRITE;
				if ($urandom_range(99) < 85) begin
					r.pix_x = 7'($urandom_range(FRAME_WIDTH - 1));
					r.pix_y = 5'($urandom_range(FRAME_HEIGHT - 1));
				end
				r.pix_value = ($urandom_range(99) < 70);
			end else begin
				r.op = OP_EMIT;
			end
			issue(r, 1'b0, '0);
		end
		start <= 1'b0;

		while (expected_bits.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
